@@ rtl/lru_page_replacement_pager_assert.svh @@
// Assertion macros for the pager RTL.
`ifndef LRU_PAGE_REPLACEMENT_PAGER_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_PAGER_ASSERT_SVH

// Condition a implies condition c in the same cycle.
`define LRUPG_ASSERT_NOW(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("pager check failed");

// Condition a implies condition c in the next cycle.
`define LRUPG_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("pager check failed");

`endif

@@ rtl/lrupg_pkg.sv @@
// Types, constants and codes of the LRU page-replacement pager.
`default_nettype none

package lrupg_pkg;

    localparam int NUM_PROCS   = 16;
    localparam int NUM_PAGES   = 16;
    localparam int PAGE_BYTES  = 128;

    localparam int PROC_W      = 4;
    localparam int PC_W        = 11;
    localparam int MASK_W      = 16;
    localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
    localparam int PAGE_W      = PC_W - PAGE_SHIFT;
    localparam int PIDX_W      = $clog2(NUM_PAGES);
    localparam int ADDR_W      = PROC_W + PIDX_W;
    localparam int STAMP_DEPTH = NUM_PROCS * NUM_PAGES;
    localparam int STAMP_W     = 31;

    localparam logic [STAMP_W-1:0] TICK_MAX   = '1;
    localparam logic [STAMP_W-1:0] TICK_RESET = STAMP_W'(1);

    typedef enum logic [1:0] {
        ACT_NONE      = 2'd0,
        ACT_PAGEIN    = 2'd1,
        ACT_EVICT     = 2'd2,
        ACT_EVICT_ALL = 2'd3
    } t_action;

    typedef struct packed {
        logic [PROC_W-1:0] proc;
        logic              active;
        logic [PC_W-1:0]   pc;
        logic [MASK_W-1:0] resident_mask;
        logic              pagein_ok;
        logic              end_of_tick;
    } t_in_item;

    typedef struct packed {
        t_action     action;
        logic [3:0]  needed_page;
        logic [3:0]  victim_page;
        logic        pagein_tried;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STAMP,
        ST_SCAN,
        ST_LAST,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic load_in;
        logic stamp_we;
        logic scan_rd;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic need_scan;
        logic scan_last;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

@@ rtl/lrupg_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lrupg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/lrupg_ctrl.sv @@
// Controller state machine of the pager: sequences stamp, victim scan and result.
`default_nettype none

module lrupg_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  lrupg_pkg::t_sts i_sts,
    output lrupg_pkg::t_cmd o_cmd
);

    lrupg_pkg::t_state r_state;
    lrupg_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lrupg_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lrupg_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = lrupg_pkg::ST_STAMP;
                end
            end
            lrupg_pkg::ST_STAMP: begin
                n_state = i_sts.need_scan ? lrupg_pkg::ST_SCAN : lrupg_pkg::ST_FINISH;
            end
            lrupg_pkg::ST_SCAN: begin
                if (i_sts.scan_last) begin
                    n_state = lrupg_pkg::ST_LAST;
                end
            end
            lrupg_pkg::ST_LAST: begin
                n_state = lrupg_pkg::ST_FINISH;
            end
            lrupg_pkg::ST_FINISH: begin
                if (i_sts.out_free) begin
                    n_state = lrupg_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lrupg_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            lrupg_pkg::ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            lrupg_pkg::ST_STAMP: begin
                o_cmd.stamp_we = 1'b1;
            end
            lrupg_pkg::ST_SCAN: begin
                o_cmd.scan_rd = 1'b1;
            end
            lrupg_pkg::ST_LAST: begin
                // final compare runs off the last registered read
            end
            lrupg_pkg::ST_FINISH: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/lrupg_dp.sv @@
// Pager datapath: item register, stamp memory, LRU search, pending marks, tick, result.
`default_nettype none

module lrupg_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lrupg_pkg::t_in_item  i_in_item,
    input  lrupg_pkg::t_cmd      i_cmd,
    output lrupg_pkg::t_sts      o_sts,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output lrupg_pkg::t_out_item o_out_item
);

    lrupg_pkg::t_in_item r_in;

    logic [lrupg_pkg::STAMP_W-1:0]     r_tick;
    logic [lrupg_pkg::NUM_PROCS-1:0]   r_pending;
    logic [lrupg_pkg::STAMP_DEPTH-1:0] r_stamp_vld;

    logic [lrupg_pkg::PIDX_W-1:0]  r_scan_idx;
    logic [lrupg_pkg::PIDX_W-1:0]  r_cmp_idx;
    logic                          r_cmp_vld;
    logic                          r_rd_vld;
    logic                          r_found;
    logic [lrupg_pkg::PIDX_W-1:0]  r_best_idx;
    logic [lrupg_pkg::STAMP_W-1:0] r_best_stamp;

    lrupg_pkg::t_out_item r_out;
    logic                 r_out_vld;
    lrupg_pkg::t_out_item n_out;

    logic [lrupg_pkg::PAGE_W-1:0]  page;
    logic [lrupg_pkg::PAGE_W-1:0]  prev_page;
    logic [lrupg_pkg::PC_W-1:0]    pc_m1;
    logic                          proc_ok;
    logic                          page_ok;
    logic                          prev_ok;
    logic                          resident;
    logic                          stamp_en;
    logic [lrupg_pkg::ADDR_W-1:0]  wr_addr;
    logic [lrupg_pkg::ADDR_W-1:0]  rd_addr;
    logic [lrupg_pkg::STAMP_W-1:0] rd_q;
    logic [lrupg_pkg::STAMP_W-1:0] rd_stamp;
    logic                          take;

    assign pc_m1     = r_in.pc - lrupg_pkg::PC_W'(1);
    assign page      = lrupg_pkg::PAGE_W'(r_in.pc >> lrupg_pkg::PAGE_SHIFT);
    assign prev_page = (r_in.pc == '0) ? '0
                                       : lrupg_pkg::PAGE_W'(pc_m1 >> lrupg_pkg::PAGE_SHIFT);

    assign proc_ok  = 32'(r_in.proc) < 32'(lrupg_pkg::NUM_PROCS);
    assign page_ok  = 32'(page) < 32'(lrupg_pkg::NUM_PAGES);
    assign prev_ok  = 32'(prev_page) < 32'(lrupg_pkg::NUM_PAGES);
    assign resident = page_ok && (32'(page) < 32'(lrupg_pkg::MASK_W))
                      && r_in.resident_mask[page];

    assign stamp_en = i_cmd.stamp_we && proc_ok && r_in.active && prev_ok;
    assign wr_addr  = {r_in.proc, lrupg_pkg::PIDX_W'(prev_page)};
    assign rd_addr  = {r_in.proc, r_scan_idx};

    lrupg_ram #(
        .WIDTH (lrupg_pkg::STAMP_W),
        .DEPTH (lrupg_pkg::STAMP_DEPTH)
    ) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (stamp_en),
        .i_waddr (wr_addr),
        .i_wdata (r_tick),
        .i_raddr (rd_addr),
        .o_rdata (rd_q)
    );

    // A never-written stamp reads as zero.
    assign rd_stamp = r_rd_vld ? rd_q : '0;
    assign take     = r_cmp_vld && r_in.resident_mask[r_cmp_idx]
                      && (!r_found || (rd_stamp < r_best_stamp));

    assign o_sts.need_scan = proc_ok && r_in.active && page_ok && !resident
                             && !r_in.pagein_ok && !r_pending[r_in.proc];
    assign o_sts.scan_last = r_scan_idx == lrupg_pkg::PIDX_W'(lrupg_pkg::NUM_PAGES - 1);
    assign o_sts.out_free  = !r_out_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stamp_vld <= '0;
        end else if (stamp_en) begin
            r_stamp_vld[wr_addr] <= 1'b1;
        end
    end

    // Scan: issue one read per cycle, compare each read in the cycle after.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_idx <= '0;
            r_cmp_vld  <= 1'b0;
            r_found    <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.scan_rd;
            if (i_cmd.load_in) begin
                r_scan_idx <= '0;
                r_found    <= 1'b0;
            end else begin
                if (i_cmd.scan_rd) begin
                    r_scan_idx <= lrupg_pkg::PIDX_W'(r_scan_idx + 1'b1);
                end
                if (take) begin
                    r_found <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_scan_idx;
        r_rd_vld  <= r_stamp_vld[rd_addr];
        if (take) begin
            r_best_idx   <= r_cmp_idx;
            r_best_stamp <= rd_stamp;
        end
    end

    always_comb begin
        n_out = '0;
        if (proc_ok) begin
            if (!r_in.active) begin
                n_out.action = lrupg_pkg::ACT_EVICT_ALL;
            end else begin
                n_out.needed_page = 4'(page);
                if (page_ok && !resident) begin
                    n_out.pagein_tried = 1'b1;
                    if (r_in.pagein_ok) begin
                        n_out.action = lrupg_pkg::ACT_PAGEIN;
                    end else if (!r_pending[r_in.proc] && r_found) begin
                        n_out.action      = lrupg_pkg::ACT_EVICT;
                        n_out.victim_page = 4'(r_best_idx);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_tick    <= lrupg_pkg::TICK_RESET;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
                if (n_out.action == lrupg_pkg::ACT_PAGEIN) begin
                    r_pending[r_in.proc] <= 1'b0;
                end else if (n_out.action == lrupg_pkg::ACT_EVICT) begin
                    r_pending[r_in.proc] <= 1'b1;
                end
                // advance the tick after the last item of a tick, saturate
                if (r_in.end_of_tick && (r_tick != lrupg_pkg::TICK_MAX)) begin
                    r_tick <= lrupg_pkg::STAMP_W'(r_tick + 1'b1);
                end
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

@@ rtl/lru_page_replacement_pager.sv @@
// Top level of the LRU page-replacement pager.
//
//   channel   direction  handshake                   payload
//   in        input      i_in_valid / o_in_ready     i_in_item  (t_in_item)
//   out       output     o_out_valid / i_out_ready   o_out_item (t_out_item)
//
// An item goes through accept, stamp write and result when no victim search is
// needed, and with a scan of NUM_PAGES pages and a last compare when it is: the
// single read port of the stamp memory feeds the compare one page stamp per cycle.
// Reset clears the per-entry stamp valid flags at once, so no clearing pass runs.
// The result register holds a result until its transfer; a new item is taken
// meanwhile, and its result waits in the last step until the register frees up.
`default_nettype none

`include "lru_page_replacement_pager_assert.svh"

module lru_page_replacement_pager (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  lrupg_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output lrupg_pkg::t_out_item o_out_item
);

    lrupg_pkg::t_cmd cmd;
    lrupg_pkg::t_sts sts;

    lrupg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lrupg_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

    `LRUPG_ASSERT_NEXT(a_accept_then_stamp, i_clk, i_rst_n, i_in_valid && o_in_ready, cmd.stamp_we)
    `LRUPG_ASSERT_NOW(a_no_result_overwrite, i_clk, i_rst_n, cmd.out_load, !o_out_valid || i_out_ready)
    `LRUPG_ASSERT_NOW(a_evict_was_tried, i_clk, i_rst_n, o_out_valid && (o_out_item.action == lrupg_pkg::ACT_EVICT), o_out_item.pagein_tried)

endmodule

`default_nettype wire
